/* hdl/cpar_pkg.sv */
// Shared types and constants of the cascaded angle/rate PID controller.
package cpar_pkg;

  // Fixed-point formats
  localparam int FRAC_BITS = 16;
  localparam int DT_FRAC   = 16;
  localparam int WORD_W    = 32;
  localparam int GAIN_W    = 31;
  localparam int DT_W      = 16;
  localparam int PROD_W    = 64;
  localparam int ACC_W     = PROD_W + 2 - FRAC_BITS;

  // Derivative divider: magnitude of (err - prev) * 2^DT_FRAC, two bits per step
  localparam int DIV_MAG_W = WORD_W + DT_FRAC;
  localparam int DIV_STEPS = DIV_MAG_W / 2;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic signed [WORD_W-1:0] S32_MAX = {1'b0, {(WORD_W-1){1'b1}}};
  localparam logic signed [WORD_W-1:0] S32_MIN = {1'b1, {(WORD_W-1){1'b0}}};

  // Input commands
  localparam logic CMD_UPDATE = 1'b0;
  localparam logic CMD_CLEAR  = 1'b1;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ANGLE_P = 3'd0,
    REG_ANGLE_I = 3'd1,
    REG_ANGLE_D = 3'd2,
    REG_RATE_P  = 3'd3,
    REG_RATE_I  = 3'd4,
    REG_RATE_D  = 3'd5
  } cfg_reg_t;

  // Loop select
  localparam logic LOOP_ANGLE = 1'b0;
  localparam logic LOOP_RATE  = 1'b1;

  typedef logic signed [ACC_W-1:0] acc_t;

  typedef struct packed {
    logic                     command;
    logic signed [WORD_W-1:0] angle_target;
    logic signed [WORD_W-1:0] angle_measured;
    logic signed [WORD_W-1:0] rate_measured;
    logic [DT_W-1:0]          time_step;
  } in_item_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] rate_setpoint;
    logic signed [WORD_W-1:0] drive;
    logic                     saturated;
  } out_item_t;

  // Datapath operations issued by the controller
  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_ERR,
    DP_INC_MUL,
    DP_INTEG,
    DP_P_TERM,
    DP_I_TERM,
    DP_DERIV,
    DP_D_MUL,
    DP_D_TERM,
    DP_LOOP_OUT,
    DP_CLEAR
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   loop_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_req;
    logic div_busy;
    logic out_free;
  } dp_status_t;

endpackage

/* hdl/cpar_div.sv */
// Iterative signed divider for the derivative term, two quotient bits per cycle.
module cpar_div import cpar_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic signed [WORD_W:0]   diff,
  input  logic [DT_W-1:0]          divisor,
  output logic                     busy,
  output logic signed [WORD_W-1:0] quotient
);

  logic [DIV_CNT_W-1:0] cnt;
  logic                 neg;
  logic [DIV_MAG_W-1:0] mag;
  logic [DIV_MAG_W-1:0] quo;
  logic [DT_W-1:0]      rem;
  logic [DT_W-1:0]      dv;

  logic [WORD_W:0]      abs_diff;
  logic [DT_W:0]        r1, r1s, r2, r2s;
  logic                 q1, q2;
  logic                 pos_ovf, neg_ovf;

  assign abs_diff = diff[WORD_W] ? (WORD_W+1)'(-diff) : diff;

  // Two restoring steps per cycle
  always_comb begin
    r1  = {rem, mag[DIV_MAG_W-1]};
    q1  = (r1 >= {1'b0, dv});
    r1s = q1 ? (r1 - {1'b0, dv}) : r1;
    r2  = {r1s[DT_W-1:0], mag[DIV_MAG_W-2]};
    q2  = (r2 >= {1'b0, dv});
    r2s = q2 ? (r2 - {1'b0, dv}) : r2;
  end

  // Clamp the quotient to the signed word range and apply the sign
  assign pos_ovf = |quo[DIV_MAG_W-1:WORD_W-1];
  assign neg_ovf = (|quo[DIV_MAG_W-1:WORD_W]) || (quo[WORD_W-1] && (|quo[WORD_W-2:0]));

  always_comb begin
    if (!neg) begin
      quotient = pos_ovf ? S32_MAX : quo[WORD_W-1:0];
    end else begin
      quotient = neg_ovf ? S32_MIN : WORD_W'(-quo[WORD_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= DIV_CNT_W'(DIV_STEPS - 1);
    end else if (busy) begin
      if (cnt == '0) begin
        busy <= 1'b0;
      end else begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  // Operand and partial result registers
  always_ff @(posedge clk) begin
    if (start) begin
      neg <= diff[WORD_W];
      mag <= {abs_diff[WORD_W-1:0], {DT_FRAC{1'b0}}};
      quo <= '0;
      rem <= '0;
      dv  <= divisor;
    end else if (busy) begin
      mag <= {mag[DIV_MAG_W-3:0], 2'b00};
      quo <= {quo[DIV_MAG_W-3:0], q1, q2};
      rem <= r2s[DT_W-1:0];
    end
  end

endmodule

/* hdl/cpar_dp.sv */
// Datapath: gain registers, loop state, shared multiplier, accumulator and output stage.
module cpar_dp import cpar_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [GAIN_W-1:0]    cfg_data,
  input  in_item_t             in_item,
  input  dp_cmd_t              cmd,
  output dp_status_t           status,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_item
);

  logic [GAIN_W-1:0] angle_p_gain, angle_i_gain, angle_d_gain;
  logic [GAIN_W-1:0] rate_p_gain, rate_i_gain, rate_d_gain;

  in_item_t                 item;
  logic signed [WORD_W-1:0] integ [2];
  logic signed [WORD_W-1:0] prev [2];
  logic signed [WORD_W-1:0] err;
  logic signed [WORD_W-1:0] deriv;
  logic signed [WORD_W-1:0] setpoint;
  logic signed [PROD_W-1:0] prod;
  acc_t                     acc;
  logic                     flag;

  logic [GAIN_W-1:0]        kp, ki, kd;
  logic signed [WORD_W-1:0] desired, measured;
  logic signed [WORD_W:0]   err_wide, integ_wide, diff;
  logic signed [WORD_W:0]   mul_a, mul_b;
  logic signed [2*WORD_W+1:0] mul_full;
  logic signed [WORD_W:0]   inc;
  acc_t                     prod_term;
  acc_t                     acc_sum;
  logic                     acc_hit;
  logic signed [WORD_W-1:0] acc_sat;
  logic                     dt_zero;
  logic                     div_busy;
  logic signed [WORD_W-1:0] div_quot;
  logic                     out_free;

  // Saturate a 33-bit signed value to the word range
  function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [WORD_W:0] v);
    logic signed [WORD_W-1:0] r;
    if (v[WORD_W] != v[WORD_W-1]) begin
      r = v[WORD_W] ? S32_MIN : S32_MAX;
    end else begin
      r = v[WORD_W-1:0];
    end
    return r;
  endfunction

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      angle_p_gain <= '0;
      angle_i_gain <= '0;
      angle_d_gain <= '0;
      rate_p_gain  <= '0;
      rate_i_gain  <= '0;
      rate_d_gain  <= '0;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        REG_ANGLE_P: angle_p_gain <= cfg_data;
        REG_ANGLE_I: angle_i_gain <= cfg_data;
        REG_ANGLE_D: angle_d_gain <= cfg_data;
        REG_RATE_P:  rate_p_gain  <= cfg_data;
        REG_RATE_I:  rate_i_gain  <= cfg_data;
        REG_RATE_D:  rate_d_gain  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Select the operands of the active loop
  assign kp       = (cmd.loop_sel == LOOP_RATE) ? rate_p_gain : angle_p_gain;
  assign ki       = (cmd.loop_sel == LOOP_RATE) ? rate_i_gain : angle_i_gain;
  assign kd       = (cmd.loop_sel == LOOP_RATE) ? rate_d_gain : angle_d_gain;
  assign desired  = (cmd.loop_sel == LOOP_RATE) ? setpoint : item.angle_target;
  assign measured = (cmd.loop_sel == LOOP_RATE) ? item.rate_measured : item.angle_measured;

  assign err_wide = {desired[WORD_W-1], desired} - {measured[WORD_W-1], measured};
  assign diff     = {err[WORD_W-1], err} - {prev[cmd.loop_sel][WORD_W-1], prev[cmd.loop_sel]};
  assign dt_zero  = (item.time_step == '0);

  // Shared multiplier operands
  always_comb begin
    unique case (cmd.op)
      DP_INC_MUL: begin
        mul_a = {err[WORD_W-1], err};
        mul_b = {{(WORD_W+1-DT_W){1'b0}}, item.time_step};
      end
      DP_INTEG: begin
        mul_a = {err[WORD_W-1], err};
        mul_b = {2'b00, kp};
      end
      DP_P_TERM: begin
        mul_a = {integ[cmd.loop_sel][WORD_W-1], integ[cmd.loop_sel]};
        mul_b = {2'b00, ki};
      end
      DP_D_MUL: begin
        mul_a = {deriv[WORD_W-1], deriv};
        mul_b = {2'b00, kd};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_full = mul_a * mul_b;

  // Integral increment, floored product terms and output clamp
  assign inc        = (WORD_W+1)'(prod >>> DT_FRAC);
  assign integ_wide = {integ[cmd.loop_sel][WORD_W-1], integ[cmd.loop_sel]} + inc;
  assign prod_term  = acc_t'(prod >>> FRAC_BITS);
  assign acc_sum    = acc + prod_term;
  assign acc_hit    = !((&acc[ACC_W-1:WORD_W-1]) || !(|acc[ACC_W-1:WORD_W-1]));
  assign acc_sat    = acc_hit ? (acc[ACC_W-1] ? S32_MIN : S32_MAX) : acc[WORD_W-1:0];

  cpar_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    ((cmd.op == DP_INC_MUL) && !dt_zero),
    .diff     (diff),
    .divisor  (item.time_step),
    .busy     (div_busy),
    .quotient (div_quot)
  );

  assign out_free = !out_valid || !out_stall;

  assign status.clear_req = (in_item.command == CMD_CLEAR);
  assign status.div_busy  = div_busy;
  assign status.out_free  = out_free;

  // Loop state: integrals and previous errors
  always_ff @(posedge clk) begin
    if (rst) begin
      integ[LOOP_ANGLE] <= '0;
      integ[LOOP_RATE]  <= '0;
      prev[LOOP_ANGLE]  <= '0;
      prev[LOOP_RATE]   <= '0;
    end else begin
      unique case (cmd.op)
        DP_INTEG:    integ[cmd.loop_sel] <= sat_word(integ_wide);
        DP_LOOP_OUT: prev[cmd.loop_sel]  <= err;
        DP_CLEAR: begin
          integ[LOOP_ANGLE] <= '0;
          integ[LOOP_RATE]  <= '0;
          prev[LOOP_ANGLE]  <= '0;
          prev[LOOP_RATE]   <= '0;
        end
        default: ;
      endcase
    end
  end

  // Working registers of one update
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      DP_LOAD: begin
        item <= in_item;
        flag <= 1'b0;
      end
      DP_ERR:     err  <= sat_word(err_wide);
      DP_INC_MUL: prod <= mul_full[PROD_W-1:0];
      DP_INTEG: begin
        flag <= flag | (integ_wide[WORD_W] != integ_wide[WORD_W-1]);
        prod <= mul_full[PROD_W-1:0];
      end
      DP_P_TERM: begin
        acc  <= prod_term;
        prod <= mul_full[PROD_W-1:0];
      end
      DP_I_TERM:  acc   <= acc_sum;
      DP_DERIV:   deriv <= dt_zero ? '0 : div_quot;
      DP_D_MUL:   prod  <= mul_full[PROD_W-1:0];
      DP_D_TERM:  acc   <= acc_sum;
      DP_LOOP_OUT: begin
        if (cmd.loop_sel == LOOP_ANGLE) begin
          setpoint <= acc_sat;
          flag     <= flag | acc_hit;
        end
      end
      default: ;
    endcase
  end

  // Output register: load a finished transaction, drop it when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((cmd.op == DP_CLEAR) ||
                 ((cmd.op == DP_LOOP_OUT) && (cmd.loop_sel == LOOP_RATE))) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == DP_CLEAR) begin
      out_item <= '0;
    end else if ((cmd.op == DP_LOOP_OUT) && (cmd.loop_sel == LOOP_RATE)) begin
      out_item.rate_setpoint <= setpoint;
      out_item.drive         <= acc_sat;
      out_item.saturated     <= flag | acc_hit;
    end
  end

`ifndef SYNTHESIS
  a_deriv_after_div: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == DP_DERIV) |-> !div_busy)
    else $error("derivative taken while divider busy");

  a_out_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    ((cmd.op == DP_CLEAR) || ((cmd.op == DP_LOOP_OUT) && (cmd.loop_sel == LOOP_RATE)))
    |-> out_free)
    else $error("output register overwritten before taken");

  a_clear_state: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == DP_CLEAR) |=> (integ[LOOP_ANGLE] == '0) && (integ[LOOP_RATE] == '0) &&
                             (prev[LOOP_ANGLE] == '0) && (prev[LOOP_RATE] == '0))
    else $error("loop state not cleared");
`endif

endmodule

/* hdl/cpar_ctrl.sv */
// Controller: sequences the angle and rate loop updates over the shared datapath.
module cpar_ctrl import cpar_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_ERR,
    S_INC,
    S_INTEG,
    S_PTERM,
    S_ITERM,
    S_DERIV,
    S_DMUL,
    S_DTERM,
    S_OUT,
    S_CLEAR
  } state_t;

  state_t state;
  logic   loop_sel;

  assign in_stall = (state != S_IDLE);

  // Decode the datapath operation of the current step
  always_comb begin
    cmd.loop_sel = loop_sel;
    unique case (state)
      S_IDLE:  cmd.op = in_valid ? DP_LOAD : DP_NOP;
      S_ERR:   cmd.op = DP_ERR;
      S_INC:   cmd.op = DP_INC_MUL;
      S_INTEG: cmd.op = DP_INTEG;
      S_PTERM: cmd.op = DP_P_TERM;
      S_ITERM: cmd.op = DP_I_TERM;
      S_DERIV: cmd.op = status.div_busy ? DP_NOP : DP_DERIV;
      S_DMUL:  cmd.op = DP_D_MUL;
      S_DTERM: cmd.op = DP_D_TERM;
      S_OUT: begin
        cmd.op = ((loop_sel == LOOP_RATE) && !status.out_free) ? DP_NOP : DP_LOOP_OUT;
      end
      S_CLEAR: cmd.op = status.out_free ? DP_CLEAR : DP_NOP;
      default: cmd.op = DP_NOP;
    endcase
  end

  // Advance through the steps of each loop
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      loop_sel <= LOOP_ANGLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          loop_sel <= LOOP_ANGLE;
          if (in_valid) begin
            state <= status.clear_req ? S_CLEAR : S_ERR;
          end
        end
        S_ERR:   state <= S_INC;
        S_INC:   state <= S_INTEG;
        S_INTEG: state <= S_PTERM;
        S_PTERM: state <= S_ITERM;
        S_ITERM: state <= S_DERIV;
        S_DERIV: begin
          if (!status.div_busy) begin
            state <= S_DMUL;
          end
        end
        S_DMUL:  state <= S_DTERM;
        S_DTERM: state <= S_OUT;
        S_OUT: begin
          if (loop_sel == LOOP_ANGLE) begin
            loop_sel <= LOOP_RATE;
            state    <= S_ERR;
          end else if (status.out_free) begin
            loop_sel <= LOOP_ANGLE;
            state    <= S_IDLE;
          end
        end
        S_CLEAR: begin
          if (status.out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("accepted transaction did not start work");

  a_deriv_advance: assert property (@(posedge clk) disable iff (rst)
    ((state == S_DERIV) && !status.div_busy) |=> (state == S_DMUL))
    else $error("derivative step stuck after divider finished");

  a_rate_after_angle: assert property (@(posedge clk) disable iff (rst)
    ((state == S_OUT) && (loop_sel == LOOP_ANGLE)) |=>
      ((state == S_ERR) && (loop_sel == LOOP_RATE)))
    else $error("rate loop did not follow angle loop");
`endif

endmodule

/* hdl/cascaded_pid_angle_rate_top.sv */
// Two-stage cascaded PID controller: angle loop feeding a rate loop, Q16.16.
//
// Input channel (in_valid / in_stall / in_item): one transaction either runs one
// cascaded update or, with command set, clears both loops' integral and last
// error and returns a result of all zeros. Output channel (out_valid /
// out_stall / out_item): exactly one result per input transaction, in order.
// Gains are written through cfg_write_en / cfg_index / cfg_data while idle.
//
// Throughput: one transaction is worked on at a time. An update runs two loop
// passes, angle then rate, each waiting on the derivative divider (two quotient
// bits per cycle) and using the steps on the shared 33x33 multiplier; with a zero
// time step the divider is skipped. A clear waits in its own step for the output
// register to free. The controller returns to idle as a result enters the output
// register, and takes the next transaction from idle.
//
// Reset (rst, synchronous): gains, loop state and the output valid flag clear.
// When the receiver stalls, the result holds in the output register; the next
// update runs up to its final step and waits there for the register to free.
module cascaded_pid_angle_rate_top import cpar_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [GAIN_W-1:0]    cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_item
);

  dp_cmd_t    cmd;
  dp_status_t status;

  cpar_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  cpar_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_item      (in_item),
    .cmd          (cmd),
    .status       (status),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_item     (out_item)
  );

endmodule

/* tb/tb.sv */
// Self-checking testbench for the cascaded angle/rate PID controller.
`timescale 1ns / 1ps

module tb;
  import cpar_pkg::*;

  // Run shape
  localparam int N_GAINS         = 6;
  localparam int PHASES          = 6;
  localparam int ITEMS_PER_PHASE = 222;
  localparam int DRAIN_PAUSE_AT  = 110;
  localparam int LONG_HOLD_AT    = 900;
  localparam int LONG_HOLD_CYC   = 400;
  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int SETTLE_CYC      = 80;

  localparam longint WORD_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam longint WORD_MIN = -64'sh0000_0000_8000_0000;

  typedef enum {G_ZERO, G_MAX, G_SMALL, G_FULL, G_MIXED} gain_style_t;

  typedef logic [N_GAINS-1:0][GAIN_W-1:0] gain_set_t;

  typedef struct {
    bit        load;
    gain_set_t gains;
    in_item_t  item;
    bit        typed;
    out_item_t want;
  } row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_write_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [GAIN_W-1:0]    cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  in_item_t             in_item = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_item_t            out_item;

  cascaded_pid_angle_rate_top u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_item      (in_item),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_item     (out_item)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Controller shadow: gains and both loops' state
  longint gain_val [N_GAINS];
  longint ang_integ, ang_prev, rate_integ, rate_prev;

  out_item_t pending_q [$];
  int        sent_count  = 0;
  int        clear_count = 0;
  int        check_count = 0;
  int        sat_count   = 0;
  int        load_count  = 0;
  int        error_count = 0;

  // Slowly moving flight-like operating point
  logic signed [WORD_W-1:0] trk_target = '0;
  logic signed [WORD_W-1:0] trk_angle  = '0;
  logic [DT_W-1:0]          trk_dt     = 16'd655;

  function automatic longint clamp_word(longint x, inout bit hit);
    if (x > WORD_MAX) begin
      hit = 1'b1;
      return WORD_MAX;
    end
    if (x < WORD_MIN) begin
      hit = 1'b1;
      return WORD_MIN;
    end
    return x;
  endfunction

  // One PID pass; error and derivative clamp silently, integral and output flag
  function automatic longint pid_stage(inout longint integ, inout longint prev,
                                       input longint kp, input longint ki,
                                       input longint kd, input longint desired,
                                       input longint measured, input longint dt,
                                       inout bit sat);
    bit     quiet;
    longint e, inc, deriv, total;
    quiet = 1'b0;
    e     = clamp_word(desired - measured, quiet);
    inc   = (e * dt) >>> DT_FRAC;
    integ = clamp_word(integ + inc, sat);
    deriv = 0;
    if (dt != 0)
      deriv = clamp_word(((e - prev) * (longint'(1) << DT_FRAC)) / dt, quiet);
    total = ((kp * e) >>> FRAC_BITS) + ((ki * integ) >>> FRAC_BITS)
          + ((kd * deriv) >>> FRAC_BITS);
    prev  = e;
    return clamp_word(total, sat);
  endfunction

  function automatic out_item_t predict_cascade(in_item_t it);
    out_item_t r;
    bit        sat;
    longint    sp, dv, dt;
    r = '0;
    if (it.command == CMD_CLEAR) begin
      ang_integ  = 0;
      ang_prev   = 0;
      rate_integ = 0;
      rate_prev  = 0;
      return r;
    end
    sat = 1'b0;
    dt  = longint'(it.time_step);
    sp  = pid_stage(ang_integ, ang_prev, gain_val[REG_ANGLE_P], gain_val[REG_ANGLE_I],
                    gain_val[REG_ANGLE_D], longint'(it.angle_target),
                    longint'(it.angle_measured), dt, sat);
    dv  = pid_stage(rate_integ, rate_prev, gain_val[REG_RATE_P], gain_val[REG_RATE_I],
                    gain_val[REG_RATE_D], sp, longint'(it.rate_measured), dt, sat);
    r.rate_setpoint = sp[WORD_W-1:0];
    r.drive         = dv[WORD_W-1:0];
    r.saturated     = sat;
    return r;
  endfunction

  function automatic logic signed [WORD_W-1:0] near(int unsigned span);
    int v;
    v = int'($urandom_range(0, 2 * span)) - int'(span);
    return v;
  endfunction

  function automatic logic signed [WORD_W-1:0] corner_word();
    case ($urandom_range(0, 5))
      0:       return S32_MIN;
      1:       return S32_MAX;
      2:       return '0;
      3:       return '1;
      4:       return 32'sd1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [GAIN_W-1:0] pick_gain(gain_style_t style);
    if (style == G_MIXED)
      style = gain_style_t'($urandom_range(0, 3));
    case (style)
      G_ZERO:  return '0;
      G_MAX:   return '1;
      G_SMALL: return GAIN_W'($urandom_range(0, 4 << FRAC_BITS));
      default: return GAIN_W'($urandom);
    endcase
  endfunction

  function automatic row_t upd_row(logic signed [WORD_W-1:0] tgt,
                                   logic signed [WORD_W-1:0] meas,
                                   logic signed [WORD_W-1:0] rate, logic [DT_W-1:0] dt);
    row_t r;
    r = '{default: '0};
    r.item = '{command: CMD_UPDATE, angle_target: tgt, angle_measured: meas,
               rate_measured: rate, time_step: dt};
    return r;
  endfunction

  function automatic row_t clr_row();
    row_t r;
    r = '{default: '0};
    r.item.command = CMD_CLEAR;
    r.typed = 1'b1;
    return r;
  endfunction

  function automatic row_t gain_row(gain_set_t g);
    row_t r;
    r = '{default: '0};
    r.load  = 1'b1;
    r.gains = g;
    return r;
  endfunction

  function automatic row_t with_want(row_t r, out_item_t w);
    r.typed = 1'b1;
    r.want  = w;
    return r;
  endfunction

  // Random update or clear: mostly tracking sequences, some corners and noise
  function automatic in_item_t next_item();
    in_item_t it;
    int       kind;
    it   = '0;
    kind = $urandom_range(0, 99);
    if (kind < 3) begin
      it.command = CMD_CLEAR;
      it.angle_target   = $urandom;
      it.angle_measured = $urandom;
      it.rate_measured  = $urandom;
      it.time_step      = DT_W'($urandom);
    end else if (kind < 75) begin
      if ($urandom_range(0, 29) == 0)
        trk_target = near(90 << FRAC_BITS);
      if ($urandom_range(0, 49) == 0)
        trk_dt = ($urandom_range(0, 9) == 0) ? '0 : DT_W'($urandom_range(16, 3277));
      trk_angle = trk_angle + ((trk_target - trk_angle) >>> 3) + near(1 << 12);
      it.command        = CMD_UPDATE;
      it.angle_target   = trk_target;
      it.angle_measured = trk_angle;
      it.rate_measured  = ((trk_target - trk_angle) >>> 2) + near(1 << 14);
      it.time_step      = trk_dt;
    end else if (kind < 88) begin
      it.command        = CMD_UPDATE;
      it.angle_target   = corner_word();
      it.angle_measured = corner_word();
      it.rate_measured  = corner_word();
      case ($urandom_range(0, 3))
        0:       it.time_step = '0;
        1:       it.time_step = 16'd1;
        2:       it.time_step = '1;
        default: it.time_step = DT_W'($urandom);
      endcase
    end else begin
      it.command        = CMD_UPDATE;
      it.angle_target   = $urandom;
      it.angle_measured = $urandom;
      it.rate_measured  = $urandom;
      it.time_step      = DT_W'($urandom);
    end
    return it;
  endfunction

  // Offer one transaction and hold it until accepted; record its expected result
  task automatic offer_item(input in_item_t it, input bit typed, input out_item_t want);
    out_item_t pred;
    in_item  <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pred = predict_cascade(it);
    pending_q.push_back(typed ? want : pred);
    sent_count++;
    if (it.command == CMD_CLEAR)
      clear_count++;
  endtask

  // Drop valid and wait for every outstanding result
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
  endtask

  // Write all six gains on back-to-back edges, block idle
  task automatic load_gains(input gain_set_t g);
    for (int i = 0; i < N_GAINS; i++) begin
      cfg_write_en <= 1'b1;
      cfg_index    <= cfg_reg_t'(i);
      cfg_data     <= g[i];
      @(posedge clk);
      gain_val[i] = longint'(g[i]);
    end
    cfg_write_en <= 1'b0;
    load_count++;
  endtask

  // Receiver stall pattern: free runs, light and heavy stalling, one long hold-off
  initial begin : rx_pacer
    int  mode, run_left, hold_left;
    bit  held;
    mode = 0;
    run_left = 0;
    hold_left = 0;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (!held && sent_count >= LONG_HOLD_AT) begin
        held = 1'b1;
        hold_left = LONG_HOLD_CYC;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (run_left == 0) begin
          mode = $urandom_range(0, 2);
          run_left = $urandom_range(20, 300);
        end
        run_left--;
        case (mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 3) == 0);
          default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin : result_check
    out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_q.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result setpoint=%0d drive=%0d sat=%0b",
                 $time, out_item.rate_setpoint, out_item.drive, out_item.saturated);
      end else begin
        want = pending_q.pop_front();
        check_count++;
        if (out_item.saturated)
          sat_count++;
        if (out_item.rate_setpoint !== want.rate_setpoint) begin
          error_count++;
          $display("%0t: rate_setpoint expected %0d actual %0d",
                   $time, want.rate_setpoint, out_item.rate_setpoint);
        end
        if (out_item.drive !== want.drive) begin
          error_count++;
          $display("%0t: drive expected %0d actual %0d", $time, want.drive, out_item.drive);
        end
        if (out_item.saturated !== want.saturated) begin
          error_count++;
          $display("%0t: saturated expected %0b actual %0b",
                   $time, want.saturated, out_item.saturated);
        end
      end
    end
  end

  // End the run when no transaction moves for too long
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || cfg_write_en || (in_valid && !in_stall) || (out_valid && !out_stall))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("%0t: no transaction for %0d cycles, %0d results outstanding",
             $time, WATCHDOG_LIMIT, pending_q.size());
    $display("cascaded_pid_angle_rate_top verification failed");
    $finish;
  end

  initial begin : stimulus
    row_t          plan [$];
    gain_set_t     g;
    gain_style_t   phase_style [PHASES];
    int            burst_left, gap;
    out_item_t     sat_hi, sat_lo;
    gain_set_t     unit_gains;

    phase_style = '{G_SMALL, G_MAX, G_FULL, G_MIXED, G_SMALL, G_MIXED};
    sat_hi = '{rate_setpoint: S32_MAX, drive: S32_MAX, saturated: 1'b1};
    sat_lo = '{rate_setpoint: S32_MIN, drive: S32_MIN, saturated: 1'b1};
    // packed order: rate D, rate I, rate P, angle D, angle I, angle P
    unit_gains = {31'h0000_0CCC, 31'h0000_4000, 31'h0002_0000,
                  31'h0000_028F, 31'h0000_8000, 31'h0001_0000};
    for (int i = 0; i < N_GAINS; i++)
      gain_val[i] = 0;
    ang_integ = 0;
    ang_prev = 0;
    rate_integ = 0;
    rate_prev = 0;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset gains, extremes, clears, saturation, dt edge cases
    plan.push_back(with_want(upd_row('0, '0, '0, '0), '0));
    plan.push_back(with_want(upd_row(S32_MAX, S32_MIN, S32_MIN, '0), '0));
    plan.push_back(clr_row());
    plan.push_back(gain_row('1));
    plan.push_back(with_want(upd_row(S32_MAX, S32_MIN, S32_MIN, '0), sat_hi));
    plan.push_back(with_want(upd_row(S32_MIN, S32_MAX, S32_MAX, '0), sat_lo));
    plan.push_back(clr_row());
    plan.push_back(gain_row(unit_gains));
    plan.push_back(upd_row(32'sh0001_0000, '0, '0, 16'd655));
    plan.push_back(upd_row(32'sh0001_0000, 32'sh0000_4000, 32'sh0000_8000, 16'd655));
    plan.push_back(upd_row(32'sh0001_0000, 32'sh0000_8000, -32'sh0000_2000, '1));
    plan.push_back(upd_row(-32'sh0010_0000, 32'sh0010_0000, '0, 16'd1));
    plan.push_back(upd_row(32'sh0005_0000, '0, 32'sh0001_0000, '0));
    plan.push_back(upd_row(S32_MAX, S32_MIN, '0, '1));
    plan.push_back(upd_row(S32_MAX, S32_MIN, '0, '1));
    plan.push_back(upd_row(S32_MAX, S32_MIN, S32_MIN, '1));
    plan.push_back(clr_row());
    plan.push_back(upd_row(S32_MIN, S32_MAX, '0, '1));
    plan.push_back(upd_row(S32_MIN, S32_MAX, S32_MAX, '1));
    plan.push_back(upd_row('0, '0, S32_MAX, 16'd1));
    plan.push_back(upd_row('0, '0, S32_MIN, 16'd1));
    plan.push_back(upd_row(32'shAAAA_AAAA, 32'sh5555_5555, 32'shAAAA_AAAA, 16'hAAAA));
    plan.push_back(upd_row(32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555, 16'h5555));
    plan.push_back(clr_row());

    foreach (plan[i]) begin
      if (plan[i].load) begin
        drain_results();
        load_gains(plan[i].gains);
      end else begin
        offer_item(plan[i].item, plan[i].typed, plan[i].want);
      end
    end

    // Random phases, each under a fresh gain setting
    burst_left = 0;
    for (int p = 0; p < PHASES; p++) begin
      drain_results();
      for (int i = 0; i < N_GAINS; i++)
        g[i] = pick_gain(phase_style[p]);
      load_gains(g);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // Hold off once until the block has handed back everything
        if (p == 2 && n == DRAIN_PAUSE_AT)
          drain_results();
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 90);
          if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
          end
        end
        burst_left--;
        offer_item(next_item(), 1'b0, '0);
      end
    end

    drain_results();
    repeat (SETTLE_CYC) @(posedge clk);

    $display("Ran %0d transactions (%0d clears) over %0d gain settings;",
             sent_count, clear_count, load_count);
    $display("checked %0d results, %0d with the saturation flag, %0d mismatches.",
             check_count, sat_count, error_count);
    if (error_count == 0)
      $display("cascaded_pid_angle_rate_top verification clean");
    else
      $display("cascaded_pid_angle_rate_top verification failed");
    $finish;
  end

endmodule
